// ===== hw/rtl/tsp_pkg.sv =====
// Shared types, constants and helper functions of the TLV scan record parser.
package tsp_pkg;

    localparam int HEADER_BYTES      = 99;
    localparam int MAGIC_BYTES       = 11;
    localparam int FIXED_FIELD_BYTES = 12;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam logic [23:0] MAX_LEN_RESET = 24'd1048576;

    // record type codes
    localparam logic [31:0] TYPE_STATUS_OPEN  = 32'd1;
    localparam logic [31:0] TYPE_STATUS_CLOSE = 32'd2;
    localparam logic [31:0] TYPE_BANNER       = 32'd3;
    localparam logic [31:0] TYPE_FILE_HEADER  = 32'd109;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_AMP    = 8'h26;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;

    // file signature, NUL terminated
    localparam logic [7:0] SIG_BYTES [12] = '{
        8'h6D, 8'h61, 8'h73, 8'h73, 8'h63, 8'h61,
        8'h6E, 8'h2F, 8'h31, 8'h2E, 8'h31, 8'h00
    };

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_BHEAD  = 2'd1,
        KIND_BTEXT  = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_MAGIC  = 2'd1,
        ERR_LENGTH = 2'd2,
        ERR_TYPE   = 2'd3
    } err_t;

    typedef struct packed {
        logic [31:0] time_stamp;
        logic [31:0] ip_address;
        logic [15:0] port_number;
        logic [7:0]  byte10;
        logic [7:0]  byte11;
    } fields_t;

    // one queued operation for the back end
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
        err_t        err;
        logic [31:0] tally;
        fields_t     fields;
    } op_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    function automatic logic is_plain(input logic [7:0] b);
        return (b >= CHAR_SPACE) && (b <= CHAR_TILDE) && (b != CHAR_LT) &&
               (b != CHAR_GT) && (b != CHAR_AMP) && (b != CHAR_BSLASH);
    endfunction

endpackage

// ===== hw/rtl/tlv_scan_record_parser.sv =====
// TLV scan record parser: one file byte in per word, status/banner/error words out.
//
// Input channel s_*: one byte of the scan file per word; s_ready drops only
// when the op queue is full. Result channel m_*: one result per word; a byte
// of banner text that needs escaping yields four words, a status record,
// banner header or error one word, most bytes none.
// Config channel cfg_*: writes max_record_length (24 bits); always ready.
// The first result word of a byte is written into the op queue and then
// loaded into the output register, from which it can be taken.
// Bytes are taken one per cycle while the op queue is not full; each escaped
// text byte holds the output for its four words, and the four-entry op
// queue between parser and output stage sets how far input runs ahead then.
// Reset (aresetn low, synchronous) returns to the file header phase, clears
// the record count and sets the length limit to 1048576.
// After an error word the parser halts and takes further bytes without
// results until reset. When m_ready is low the output word holds, the queue
// fills, and then s_ready goes low.
module tlv_scan_record_parser import tsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_item_kind,
    output logic [31:0] m_time_stamp,
    output logic [31:0] m_ip_address,
    output logic [15:0] m_port_number,
    output logic [7:0]  m_tcp_flags,
    output logic [7:0]  m_ttl_value,
    output logic [15:0] m_banner_protocol,
    output logic [7:0]  m_text_char,
    output logic        m_run_last,
    output logic        m_record_end,
    output logic [1:0]  m_error_code,
    output logic [31:0] m_records_done
);

    logic [23:0] max_len_reg;
    logic        q_full, q_push, q_pop, q_head_valid;
    op_t         q_push_op, q_head_op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    tsp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .max_len     (max_len_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (q_push_op)
    );

    tsp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    tsp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (q_head_valid),
        .head_op           (q_head_op),
        .pop               (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_kind       (m_item_kind),
        .m_time_stamp      (m_time_stamp),
        .m_ip_address      (m_ip_address),
        .m_port_number     (m_port_number),
        .m_tcp_flags       (m_tcp_flags),
        .m_ttl_value       (m_ttl_value),
        .m_banner_protocol (m_banner_protocol),
        .m_text_char       (m_text_char),
        .m_run_last        (m_run_last),
        .m_record_end      (m_record_end),
        .m_error_code      (m_error_code),
        .m_records_done    (m_records_done)
    );

endmodule

// ===== hw/rtl/tsp_front.sv =====
// Front end: header check and varint/record parsing, emits one op per byte at most.
module tsp_front import tsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [23:0] max_len,
    input  logic        q_full,
    output logic        q_push,
    output op_t         q_op
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [6:0]  hcount_reg, hcount_next;
    logic        magic_ok_reg, magic_ok_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] length_reg, length_next;
    logic [23:0] pcount_reg, pcount_next;
    logic [31:0] tally_reg, tally_next;
    logic [7:0]  field_reg [FIXED_FIELD_BYTES];
    logic [7:0]  field_next [FIXED_FIELD_BYTES];

    logic        accept;
    logic        do_finish;
    logic        last;
    logic [31:0] varint_type;
    logic [31:0] varint_len;

    assign s_ready     = !q_full;
    assign accept      = s_valid && s_ready;
    assign varint_type = {type_reg[24:0], s_data_byte[6:0]};
    assign varint_len  = {length_reg[24:0], s_data_byte[6:0]};

    always_comb begin
        phase_next    = phase_reg;
        hcount_next   = hcount_reg;
        magic_ok_next = magic_ok_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        pcount_next   = pcount_reg;
        tally_next    = tally_reg;
        field_next    = field_reg;
        do_finish     = 1'b0;
        last          = 1'b0;
        q_push        = 1'b0;
        q_op          = '0;
        q_op.kind     = KIND_STATUS;
        q_op.err      = ERR_NONE;
        q_op.data     = s_data_byte;

        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hcount_reg < 7'(MAGIC_BYTES) &&
                        s_data_byte != SIG_BYTES[hcount_reg[3:0]]) begin
                        magic_ok_next = 1'b0;
                    end
                    hcount_next = hcount_reg + 7'd1;
                    if (hcount_next >= 7'(HEADER_BYTES)) begin
                        if (!magic_ok_next) begin
                            q_push      = 1'b1;
                            q_op.kind   = KIND_ERROR;
                            q_op.err    = ERR_MAGIC;
                            phase_next  = PH_HALT;
                        end else begin
                            phase_next = PH_TYPE;
                            type_next  = '0;
                        end
                    end
                end
                PH_TYPE: begin
                    type_next = varint_type;
                    if (!s_data_byte[7]) begin
                        phase_next  = PH_LENGTH;
                        length_next = '0;
                    end
                end
                PH_LENGTH: begin
                    length_next = varint_len;
                    if (!s_data_byte[7]) begin
                        pcount_next = '0;
                        if (varint_len > {8'd0, max_len}) begin
                            q_push     = 1'b1;
                            q_op.kind  = KIND_ERROR;
                            q_op.err   = ERR_LENGTH;
                            phase_next = PH_HALT;
                        end else if (varint_len == '0) begin
                            do_finish = 1'b1;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (pcount_reg < 24'(FIXED_FIELD_BYTES)) begin
                        field_next[pcount_reg[3:0]] = s_data_byte;
                    end
                    pcount_next = pcount_reg + 24'd1;
                    last        = {8'd0, pcount_next} >= length_reg;
                    if (type_reg == TYPE_BANNER) begin
                        if (pcount_reg == 24'(FIXED_FIELD_BYTES - 1) &&
                            length_reg > 32'(FIXED_FIELD_BYTES)) begin
                            q_push    = 1'b1;
                            q_op.kind = KIND_BHEAD;
                        end else if (pcount_reg >= 24'(FIXED_FIELD_BYTES)) begin
                            q_push    = 1'b1;
                            q_op.kind = KIND_BTEXT;
                            q_op.last = last;
                        end
                    end
                    do_finish = last;
                end
                PH_HALT: begin
                end
                default: begin
                end
            endcase

            if (do_finish) begin
                if (type_reg != TYPE_STATUS_OPEN && type_reg != TYPE_STATUS_CLOSE &&
                    type_reg != TYPE_BANNER && type_reg != TYPE_FILE_HEADER) begin
                    q_push     = 1'b1;
                    q_op.kind  = KIND_ERROR;
                    q_op.err   = ERR_TYPE;
                    phase_next = PH_HALT;
                end else begin
                    if ((type_reg == TYPE_STATUS_OPEN || type_reg == TYPE_STATUS_CLOSE) &&
                        length_next >= 32'(FIXED_FIELD_BYTES)) begin
                        q_push    = 1'b1;
                        q_op.kind = KIND_STATUS;
                    end
                    if (tally_reg != '1) begin
                        tally_next = tally_reg + 32'd1;
                    end
                    phase_next = PH_TYPE;
                    type_next  = '0;
                end
            end
        end

        // fields include the byte taken this cycle
        q_op.fields.time_stamp  = {field_next[0], field_next[1], field_next[2], field_next[3]};
        q_op.fields.ip_address  = {field_next[4], field_next[5], field_next[6], field_next[7]};
        q_op.fields.port_number = {field_next[8], field_next[9]};
        q_op.fields.byte10      = field_next[10];
        q_op.fields.byte11      = field_next[11];
        q_op.tally              = tally_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hcount_reg   <= '0;
            magic_ok_reg <= 1'b1;
            type_reg     <= '0;
            length_reg   <= '0;
            pcount_reg   <= '0;
            tally_reg    <= '0;
        end else begin
            phase_reg    <= phase_next;
            hcount_reg   <= hcount_next;
            magic_ok_reg <= magic_ok_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            pcount_reg   <= pcount_next;
            tally_reg    <= tally_next;
        end
    end

    always_ff @(posedge aclk) begin
        field_reg <= field_next;
    end

endmodule

// ===== hw/rtl/tsp_fifo.sv =====
// Short op queue between the parser front end and the output back end.
module tsp_fifo import tsp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head_op
);

    op_t                   mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push, do_pop;

    assign full       = count_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_op    = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hw/rtl/tsp_back.sv =====
// Back end: expands queued ops into result words, escaping banner text bytes.
module tsp_back import tsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  op_t         head_op,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_item_kind,
    output logic [31:0] m_time_stamp,
    output logic [31:0] m_ip_address,
    output logic [15:0] m_port_number,
    output logic [7:0]  m_tcp_flags,
    output logic [7:0]  m_ttl_value,
    output logic [15:0] m_banner_protocol,
    output logic [7:0]  m_text_char,
    output logic        m_run_last,
    output logic        m_record_end,
    output logic [1:0]  m_error_code,
    output logic [31:0] m_records_done
);

    logic        m_valid_reg;
    logic [1:0]  beat_reg;
    logic        load, escape, final_beat;
    logic [7:0]  text;

    logic [1:0]  kind_reg;
    logic [31:0] ts_reg, ip_reg, done_reg;
    logic [15:0] port_reg, proto_reg;
    logic [7:0]  flags_reg, ttl_reg, char_reg;
    logic        run_last_reg, rec_end_reg;
    logic [1:0]  err_reg;

    assign load       = !m_valid_reg || m_ready;
    assign escape     = head_op.kind == KIND_BTEXT && !is_plain(head_op.data);
    assign final_beat = !escape || beat_reg == 2'd3;
    assign pop        = load && head_valid && final_beat;

    always_comb begin
        case (beat_reg)
            2'd0:    text = CHAR_BSLASH;
            2'd1:    text = CHAR_X;
            2'd2:    text = hex_char(head_op.data[7:4]);
            default: text = hex_char(head_op.data[3:0]);
        endcase
        if (!escape) begin
            text = head_op.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            beat_reg    <= '0;
        end else if (load) begin
            m_valid_reg <= head_valid;
            if (head_valid) begin
                beat_reg <= final_beat ? 2'd0 : beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            kind_reg     <= head_op.kind;
            ts_reg       <= '0;
            ip_reg       <= '0;
            port_reg     <= '0;
            flags_reg    <= '0;
            ttl_reg      <= '0;
            proto_reg    <= '0;
            char_reg     <= '0;
            rec_end_reg  <= 1'b0;
            err_reg      <= ERR_NONE;
            run_last_reg <= final_beat;
            done_reg     <= head_op.tally;
            unique case (head_op.kind) inside
                KIND_STATUS: begin
                    ts_reg    <= head_op.fields.time_stamp;
                    ip_reg    <= head_op.fields.ip_address;
                    port_reg  <= head_op.fields.port_number;
                    flags_reg <= head_op.fields.byte10;
                    ttl_reg   <= head_op.fields.byte11;
                end
                KIND_BHEAD, KIND_BTEXT: begin
                    ts_reg    <= head_op.fields.time_stamp;
                    ip_reg    <= head_op.fields.ip_address;
                    port_reg  <= head_op.fields.port_number;
                    proto_reg <= {head_op.fields.byte10, head_op.fields.byte11};
                    if (head_op.kind == KIND_BTEXT) begin
                        char_reg    <= text;
                        rec_end_reg <= final_beat && head_op.last;
                    end
                end
                default: begin
                    err_reg <= head_op.err;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_item_kind       = kind_reg;
    assign m_time_stamp      = ts_reg;
    assign m_ip_address      = ip_reg;
    assign m_port_number     = port_reg;
    assign m_tcp_flags       = flags_reg;
    assign m_ttl_value       = ttl_reg;
    assign m_banner_protocol = proto_reg;
    assign m_text_char       = char_reg;
    assign m_run_last        = run_last_reg;
    assign m_record_end      = rec_end_reg;
    assign m_error_code      = err_reg;
    assign m_records_done    = done_reg;

endmodule
